>>> rtl/hsd_pkg.sv
// Shared types and constants for the hash set deduplicator.
package hsd_pkg;

  localparam int VALUE_W     = 32;
  localparam int HASH_BITS_W = 4;
  localparam int K_W         = 5;
  localparam int EPOCH_W     = 8;

  localparam logic [HASH_BITS_W-1:0] HASH_BITS_RST = 4'd10;
  localparam logic [VALUE_W-1:0]     HASH_MULT     = 32'h9E37_79B1;
  localparam logic [VALUE_W-1:0]     VALUE_MIN     = 32'h8000_0000;
  localparam logic [EPOCH_W-1:0]     EPOCH_FIRST   = 8'd1;
  localparam logic [EPOCH_W-1:0]     EPOCH_LAST    = 8'hFF;
  localparam logic [EPOCH_W-1:0]     EPOCH_NONE    = 8'd0;

  localparam logic STATUS_STORED = 1'b0;
  localparam logic STATUS_FULL   = 1'b1;

  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_HASH,
    ST_HOME,
    ST_PROBE,
    ST_EMIT
  } state_e;

endpackage

>>> rtl/hsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hsd_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/hsd_hash.sv
// Multiplicative hash: registered product, then shift down to the home slot; the minimum value maps to slot 0.
module hsd_hash
  import hsd_pkg::*;
#(
  parameter int SLOT_W = 10
) (
  input  logic               clk_i,
  input  logic [VALUE_W-1:0] value_i,
  input  logic [K_W-1:0]     k_i,
  output logic [SLOT_W-1:0]  home_o
);

  logic [VALUE_W-1:0] prod_q;
  logic               is_min_q;
  logic [5:0]         shamt;
  logic [VALUE_W-1:0] shifted;

  always_ff @(posedge clk_i) begin
    prod_q   <= value_i * HASH_MULT;
    is_min_q <= (value_i == VALUE_MIN);
  end

  assign shamt   = 6'd32 - 6'(k_i);
  assign shifted = prod_q >> shamt;
  assign home_o  = is_min_q ? '0 : shifted[SLOT_W-1:0];

endmodule

>>> rtl/hash_set_deduplicator_top.sv
// Top level: hash set deduplicator with linear-probing table and probe sequencer.
//
//  channel | signals                                    | dir
//  in      | in_valid_i, in_stall_o, value_i, start_of_set_i | sink
//  out     | out_valid_o, out_stall_i, unique_value_o, status_o | source
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_hash_bits_i   | sink
//
// An item passes the hash, home and probe states, probing P slots (one table read
// per cycle, P bounded by 2^K); repeats and full results end on the last probe.
// Reset runs a wipe of all 2^floor(log2(TABLE_SLOTS)) slots, input stalled.
// Every 255th start_of_set repeats that wipe before the item is hashed.
// A stalled result is held in the output register; a second result that is ready
// before the first leaves waits in the sequencer, and the input stalls meanwhile.
module hash_set_deduplicator_top
  import hsd_pkg::*;
#(
  parameter int TABLE_SLOTS   = 1024,
  parameter int MIN_HASH_BITS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic                      start_of_set_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [VALUE_W-1:0] unique_value_o,
  output logic                      status_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [HASH_BITS_W-1:0]    cfg_hash_bits_i
);

  localparam int MAX_BITS = $clog2(TABLE_SLOTS + 1) - 1;
  localparam int SLOT_W   = MAX_BITS;
  localparam int DEPTH    = 1 << MAX_BITS;
  localparam int K_LO     = (MIN_HASH_BITS < MAX_BITS) ? MIN_HASH_BITS : MAX_BITS;
  localparam int WORD_W   = EPOCH_W + VALUE_W;

  state_e                 state_q, state_d;
  logic [HASH_BITS_W-1:0] hash_bits_q;
  logic [VALUE_W-1:0]     value_q, value_d;
  logic [EPOCH_W-1:0]     epoch_q, epoch_d;
  logic [SLOT_W-1:0]      slot_q, slot_d;
  logic [SLOT_W-1:0]      n_q, n_d;
  logic [SLOT_W-1:0]      wipe_q, wipe_d;
  logic                   pend_q, pend_d;
  logic                   res_status_q, res_status_d;
  logic                   out_valid_q, out_valid_d;
  logic [VALUE_W-1:0]     out_value_q, out_value_d;
  logic                   out_status_q, out_status_d;

  logic [K_W-1:0]    hb_ext, k;
  logic [SLOT_W-1:0] slots_m1, next_slot, home;
  logic              in_acc, out_free, wipe_done;
  logic              we, re;
  logic [SLOT_W-1:0] waddr, raddr;
  logic [WORD_W-1:0] wdata, rdata;
  logic [EPOCH_W-1:0] rd_epoch;
  logic [VALUE_W-1:0] rd_value;
  logic              slot_free, slot_hit, probe_last;

  // active slot count
  always_comb begin
    hb_ext = K_W'(hash_bits_q);
    if (hb_ext < K_W'(K_LO)) begin
      k = K_W'(K_LO);
    end else if (hb_ext > K_W'(MAX_BITS)) begin
      k = K_W'(MAX_BITS);
    end else begin
      k = hb_ext;
    end
  end

  assign slots_m1  = SLOT_W'(((SLOT_W + 1)'(1) << k) - (SLOT_W + 1)'(1));
  assign next_slot = (slot_q + SLOT_W'(1)) & slots_m1;

  hsd_hash #(
    .SLOT_W(SLOT_W)
  ) u_hash (
    .clk_i  (clk_i),
    .value_i(value_q),
    .k_i    (k),
    .home_o (home)
  );

  hsd_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd_epoch   = rdata[VALUE_W +: EPOCH_W];
  assign rd_value   = rdata[VALUE_W-1:0];
  assign slot_free  = (rd_epoch != epoch_q);
  assign slot_hit   = (rd_value == value_q);
  assign probe_last = (n_q == slots_m1);

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign wipe_done  = (wipe_q == '1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_WIPE: begin
        if (wipe_done) begin
          state_d = pend_q ? ST_HASH : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (start_of_set_i && epoch_q == EPOCH_LAST) ? ST_WIPE : ST_HASH;
        end
      end
      ST_HASH: state_d = ST_HOME;
      ST_HOME: state_d = ST_PROBE;
      ST_PROBE: begin
        if (slot_free || (!slot_hit && probe_last)) begin
          state_d = out_free ? ST_IDLE : ST_EMIT;
        end else if (slot_hit) begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and table access
  always_comb begin
    value_d      = value_q;
    epoch_d      = epoch_q;
    slot_d       = slot_q;
    n_d          = n_q;
    wipe_d       = wipe_q;
    pend_d       = pend_q;
    res_status_d = res_status_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    we           = 1'b0;
    waddr        = slot_q;
    wdata        = {epoch_q, value_q};
    re           = 1'b0;
    raddr        = home;
    case (state_q)
      ST_WIPE: begin
        we     = 1'b1;
        waddr  = wipe_q;
        wdata  = {EPOCH_NONE, VALUE_W'(0)};
        wipe_d = wipe_q + SLOT_W'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          value_d = VALUE_W'(value_i);
          pend_d  = 1'b1;
          wipe_d  = '0;
          if (start_of_set_i) begin
            epoch_d = (epoch_q == EPOCH_LAST) ? EPOCH_FIRST : epoch_q + EPOCH_W'(1);
          end
        end
      end
      ST_HOME: begin
        re     = 1'b1;
        raddr  = home;
        slot_d = home;
        n_d    = '0;
      end
      ST_PROBE: begin
        if (slot_free || (!slot_hit && probe_last)) begin
          res_status_d = slot_free ? STATUS_STORED : STATUS_FULL;
          we           = slot_free;
          if (out_free) begin
            out_valid_d  = 1'b1;
            out_value_d  = value_q;
            out_status_d = res_status_d;
          end
        end else if (!slot_hit) begin
          re     = 1'b1;
          raddr  = next_slot;
          slot_d = next_slot;
          n_d    = n_q + SLOT_W'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = value_q;
          out_status_d = res_status_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_WIPE;
      hash_bits_q <= HASH_BITS_RST;
      epoch_q     <= EPOCH_FIRST;
      wipe_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      epoch_q     <= epoch_d;
      wipe_q      <= wipe_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        hash_bits_q <= cfg_hash_bits_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q      <= value_d;
    slot_q       <= slot_d;
    n_q          <= n_d;
    res_status_q <= res_status_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign unique_value_o = signed'(out_value_q);
  assign status_o       = out_status_q;

endmodule

>>> rtl/hsd_checker.sv
// Port-level checks for the hash set deduplicator, bound to the top level.
module hsd_checker
  import hsd_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic signed [VALUE_W-1:0] unique_value_o,
  input logic                      status_o
);

  // a result transaction holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(unique_value_o) && $stable(status_o))
    else $error("result payload changed while stalled");

  // one input transaction at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while previous transaction in flight");

  // a new result comes only from an input transaction in flight
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no transaction in flight");

endmodule

bind hash_set_deduplicator_top hsd_checker u_hsd_checker (.*);
